@@ hw/rtl/fsft_pkg.sv @@
// ----------------------------------------------------------------------------
// fsft_pkg: shared definitions for the free space fit table
// Field widths, action and fit method codes, pointer operations, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fsft_pkg;

    localparam int DATA_W              = 31;
    localparam int ACT_W               = 2;
    localparam int METHOD_W            = 2;
    localparam int COUNT_OUT_W         = 7;
    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [METHOD_W-1:0] FIT_FIRST        = 2'd0;
    localparam logic [METHOD_W-1:0] FIT_BEST         = 2'd1;
    localparam logic [METHOD_W-1:0] FIT_WORST        = 2'd2;
    localparam logic [METHOD_W-1:0] FIT_METHOD_RESET = FIT_BEST;

    localparam int PTR_OP_W = 3;
    localparam logic [PTR_OP_W-1:0] PTR_HOLD  = 3'd0;
    localparam logic [PTR_OP_W-1:0] PTR_COUNT = 3'd1;
    localparam logic [PTR_OP_W-1:0] PTR_ZERO  = 3'd2;
    localparam logic [PTR_OP_W-1:0] PTR_LAST  = 3'd3;
    localparam logic [PTR_OP_W-1:0] PTR_DEC   = 3'd4;
    localparam logic [PTR_OP_W-1:0] PTR_INC   = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic                load;
        logic [PTR_OP_W-1:0] ptr_op;
        logic                shift_wr;
        logic                place_wr;
        logic                set_full;
        logic                set_hit;
        logic                clear_cnt;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0]    act;
        logic [METHOD_W-1:0] method;
        logic                tbl_full;
        logic                tbl_empty;
        logic                rd_gt;
        logic                rd_ge;
        logic                ptr_one;
        logic                ptr_last;
        logic                out_free;
    } status_t;

endpackage

@@ hw/rtl/free_space_fit_table.sv @@
// ----------------------------------------------------------------------------
// free_space_fit_table: size-ordered free region table with fit search
// Top level joining the request sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Each request returns exactly one result. The table sits in a single memory
// with one write and one registered read per cycle, and every walk moves one
// entry per cycle: an insert shifts each larger entry up one place from the
// top, then places the new one; a first or best fit search walks up from the
// bottom until an entry fits or the last is read; a worst fit search reads
// only the last entry; a clear, a rejected insert, a find on an empty table
// or under the unused fit method, or an unused action goes straight to the
// result. The next request is taken while a result still waits in the output
// register; a request that finishes before that result is taken waits for it.
module free_space_fit_table #(
    parameter int TABLE_DEPTH = fsft_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fsft_pkg::METHOD_W-1:0]       cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fsft_pkg::ACT_W-1:0]          s_action,
    input  logic [fsft_pkg::DATA_W-1:0]         s_entry_offset,
    input  logic [fsft_pkg::DATA_W-1:0]         s_entry_size,
    input  logic [fsft_pkg::DATA_W-1:0]         s_request_size,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [fsft_pkg::DATA_W-1:0]         m_found_offset,
    output logic                                m_table_full,
    output logic [fsft_pkg::COUNT_OUT_W-1:0]    m_entry_count
);
    import fsft_pkg::*;

    cmd_t    cmd;
    status_t sts;

    fsft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fsft_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_action       (s_action),
        .s_entry_offset (s_entry_offset),
        .s_entry_size   (s_entry_size),
        .s_request_size (s_request_size),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_found_offset (m_found_offset),
        .m_table_full   (m_table_full),
        .m_entry_count  (m_entry_count)
    );

endmodule

@@ hw/rtl/fsft_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsft_ctrl: request sequencer
// Takes a request, dispatches on its action, steps the table walk for
// sorted insert or fit search, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module fsft_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fsft_pkg::status_t sts,
    output fsft_pkg::cmd_t    cmd
);
    import fsft_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SHIFT    = 3'd2;
    localparam logic [2:0] ST_PLACE    = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = PTR_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.act)
                    ACT_INSERT: begin
                        if (sts.tbl_full) begin
                            cmd.set_full = 1'b1;
                            state_next   = ST_DONE;
                        end else if (sts.tbl_empty) begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = ST_PLACE;
                        end else begin
                            cmd.ptr_op = PTR_COUNT;
                            state_next = ST_SHIFT;
                        end
                    end
                    ACT_FIND: begin
                        if (sts.tbl_empty) begin
                            state_next = ST_DONE;
                        end else if (sts.method == FIT_WORST) begin
                            cmd.ptr_op = PTR_LAST;
                            state_next = ST_SCAN;
                        end else if (sts.method inside {FIT_FIRST, FIT_BEST}) begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = ST_SCAN;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    ACT_CLEAR: begin
                        cmd.clear_cnt = 1'b1;
                        state_next    = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SHIFT: begin
                if (sts.rd_gt) begin
                    cmd.shift_wr = 1'b1;
                    cmd.ptr_op   = PTR_DEC;
                    if (sts.ptr_one) begin
                        state_next = ST_PLACE;
                    end
                end else begin
                    cmd.place_wr = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_PLACE: begin
                cmd.place_wr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_SCAN: begin
                if (sts.rd_ge) begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_DONE;
                end else if (sts.ptr_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/fsft_datapath.sv @@
// ----------------------------------------------------------------------------
// fsft_datapath: region table, walk pointer and result registers
// Holds the size-sorted region memory, the entry count, the latched request,
// the fit method register and the output register stage.
// ----------------------------------------------------------------------------
module fsft_datapath #(
    parameter int TABLE_DEPTH = fsft_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fsft_pkg::METHOD_W-1:0]       cfg_wr_data,
    input  logic [fsft_pkg::ACT_W-1:0]          s_action,
    input  logic [fsft_pkg::DATA_W-1:0]         s_entry_offset,
    input  logic [fsft_pkg::DATA_W-1:0]         s_entry_size,
    input  logic [fsft_pkg::DATA_W-1:0]         s_request_size,
    input  fsft_pkg::cmd_t                      cmd,
    output fsft_pkg::status_t                   sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [fsft_pkg::DATA_W-1:0]         m_found_offset,
    output logic                                m_table_full,
    output logic [fsft_pkg::COUNT_OUT_W-1:0]    m_entry_count
);
    import fsft_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_q;

    logic [METHOD_W-1:0] method_reg;
    logic [ACT_W-1:0]    act_reg;
    logic [DATA_W-1:0]   new_off_reg;
    logic [DATA_W-1:0]   new_size_reg;
    logic [DATA_W-1:0]   need_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic [AW-1:0]       rd_addr;
    logic                found_reg;
    logic [DATA_W-1:0]   off_reg;
    logic                full_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                m_found_reg;
    logic [DATA_W-1:0]   m_offset_reg;
    logic                m_full_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;
    logic [31:0]         count_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= FIT_METHOD_RESET;
        end else if (cfg_wr_en) begin
            method_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg      <= s_action;
            new_off_reg  <= s_entry_offset;
            new_size_reg <= s_entry_size;
            need_reg     <= s_request_size;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear_cnt) begin
            count_next = '0;
        end else if (cmd.place_wr) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        case (cmd.ptr_op)
            PTR_HOLD:  ptr_next = ptr_reg;
            PTR_COUNT: ptr_next = AW'(count_reg);
            PTR_ZERO:  ptr_next = '0;
            PTR_LAST:  ptr_next = AW'(count_reg - CW'(1));
            PTR_DEC:   ptr_next = ptr_reg - AW'(1);
            PTR_INC:   ptr_next = ptr_reg + AW'(1);
            default:   ptr_next = ptr_reg;
        endcase
    end

    // insert walks down, reading one below the pointer; search walks up
    assign rd_addr = (act_reg == ACT_INSERT) ? (ptr_next - AW'(1)) : ptr_next;

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_wr) begin
            mem[ptr_reg] <= rd_q;
        end else if (cmd.place_wr) begin
            mem[ptr_reg] <= '{offset: new_off_reg, size: new_size_reg};
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            off_reg   <= '0;
            full_reg  <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
            off_reg   <= '0;
            full_reg  <= 1'b0;
        end else begin
            if (cmd.set_hit) begin
                found_reg <= 1'b1;
                off_reg   <= rd_q.offset;
            end
            if (cmd.set_full) begin
                full_reg <= 1'b1;
            end
        end
    end

    assign sts.act       = act_reg;
    assign sts.method    = method_reg;
    assign sts.tbl_full  = (count_reg == CW'(TABLE_DEPTH));
    assign sts.tbl_empty = (count_reg == '0);
    assign sts.rd_gt     = (rd_q.size > new_size_reg);
    assign sts.rd_ge     = (rd_q.size >= need_reg);
    assign sts.ptr_one   = (ptr_reg == AW'(1));
    assign sts.ptr_last  = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign count_ext = 32'(count_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_found_reg  <= found_reg;
            m_offset_reg <= off_reg;
            m_full_reg   <= full_reg;
            m_count_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_found_offset = m_offset_reg;
    assign m_table_full   = m_full_reg;
    assign m_entry_count  = m_count_reg;

endmodule
